[src/bsfr_pkg.sv]
// Shared types, constants and result codes of the byte-stuffed frame receiver.
`default_nettype none

package bsfr_pkg;

    // Width of the wrapping packet counters (8 to 64); they are reported in 32 bits.
    localparam int COUNT_W = 32;

    // APB address width: six 32-bit registers at byte addresses 0, 4, ..., 20.
    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = ADDR_W - 2;

    // Frame layout.
    localparam int HDR_BYTES = 6;
    localparam int LEN_HIGH_POS = 2;
    localparam int LEN_LOW_POS = 3;
    localparam int CRC_LEN = 2;
    localparam int POS_W = 17;

    // Result kinds, carried on m_tuser.
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_CRC     = 3'd3;
    localparam logic [2:0] KIND_GOOD    = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    // Error causes.
    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_RESTART = 3'd1;
    localparam logic [2:0] CAUSE_SHORT   = 3'd2;
    localparam logic [2:0] CAUSE_CRC     = 3'd3;
    localparam logic [2:0] CAUSE_LENGTH  = 3'd4;
    localparam logic [2:0] CAUSE_EXTRA   = 3'd5;

    // Register reset values.
    localparam logic [7:0]  START_RST = 8'd2;
    localparam logic [7:0]  END_RST   = 8'd3;
    localparam logic [7:0]  ESC_RST   = 8'd27;
    localparam logic [15:0] MAXP_RST  = 16'd1024;
    localparam logic [15:0] POLY_RST  = 16'h1021;
    localparam logic [15:0] INIT_RST  = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [7:0]  escape_byte;
        logic [15:0] max_payload;
        logic [15:0] crc_polynomial;
        logic [15:0] crc_initial;
    } cfg_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [2:0]       error_cause;
        logic [7:0]       data_byte;
        logic [POS_W-1:0] byte_index;
        logic [7:0]       msg_first;
        logic [7:0]       msg_second;
        logic [15:0]      length_field;
        logic [7:0]       cmd_first;
        logic [7:0]       cmd_second;
        logic [31:0]      good_count;
        logic [31:0]      bad_count;
    } res_t;

    // Report a counter of COUNT_W bits in 32 bits: zero-extend or truncate.
    function automatic logic [31:0] count_out(input logic [COUNT_W-1:0] v);
        logic [COUNT_W+31:0] ext;
        ext = {32'd0, v};
        return ext[31:0];
    endfunction

endpackage

`default_nettype wire

[src/bsfr_regs.sv]
// APB configuration registers of the frame receiver.
`default_nettype none

module bsfr_regs
    import bsfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    localparam logic [REG_IDX_W-1:0] REG_START = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_END   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ESC   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAXP  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_POLY  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INIT  = 3'd5;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte     <= START_RST;
            cfg_reg.end_byte       <= END_RST;
            cfg_reg.escape_byte    <= ESC_RST;
            cfg_reg.max_payload    <= MAXP_RST;
            cfg_reg.crc_polynomial <= POLY_RST;
            cfg_reg.crc_initial    <= INIT_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_START: cfg_reg.start_byte     <= pwdata[7:0];
                REG_END:   cfg_reg.end_byte       <= pwdata[7:0];
                REG_ESC:   cfg_reg.escape_byte    <= pwdata[7:0];
                REG_MAXP:  cfg_reg.max_payload    <= pwdata[15:0];
                REG_POLY:  cfg_reg.crc_polynomial <= pwdata[15:0];
                REG_INIT:  cfg_reg.crc_initial    <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START: prdata = {24'd0, cfg_reg.start_byte};
            REG_END:   prdata = {24'd0, cfg_reg.end_byte};
            REG_ESC:   prdata = {24'd0, cfg_reg.escape_byte};
            REG_MAXP:  prdata = {16'd0, cfg_reg.max_payload};
            REG_POLY:  prdata = {16'd0, cfg_reg.crc_polynomial};
            REG_INIT:  prdata = {16'd0, cfg_reg.crc_initial};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[src/bsfr_deframer.sv]
// Frame state, unstuffing, byte routing, CRC-16 check and counters.
`default_nettype none

module bsfr_deframer
    import bsfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    input  wire cfg_t       cfg,
    output res_t            res
);

    localparam logic [1:0] MODE_WAIT  = 2'd0;
    localparam logic [1:0] MODE_FRAME = 2'd1;
    localparam logic [1:0] MODE_ESC   = 2'd2;

    localparam logic [POS_W-1:0] HDR_END  = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] LEN_LOW  = POS_W'(LEN_LOW_POS);
    localparam logic [1:0]       CRC_DONE = 2'(CRC_LEN);

    // One MSB-first CRC-16 update with a whole byte: eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc_in ^ {b, 8'd0};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ poly;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic [1:0]         mode_reg, mode_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [15:0]        length_reg, length_next;
    logic [15:0]        rx_crc_reg, rx_crc_next;
    logic [1:0]         crc_cnt_reg, crc_cnt_next;
    logic [15:0]        crc_reg, crc_next;
    logic [COUNT_W-1:0] good_reg, good_next;
    logic [COUNT_W-1:0] bad_reg, bad_next;
    logic [7:0]         hdr_reg [HDR_BYTES];

    logic               hdr_we;
    logic               route;
    logic               bump_bad;
    logic [7:0]         byte_v;
    logic [POS_W-1:0]   body_end;
    logic [15:0]        len_new;
    logic [15:0]        crc_upd;

    assign body_end = HDR_END + {1'b0, length_reg};
    assign len_new  = {hdr_reg[LEN_HIGH_POS], byte_v};

    always_comb
    begin
        mode_next     = mode_reg;
        position_next = position_reg;
        length_next   = length_reg;
        rx_crc_next   = rx_crc_reg;
        crc_cnt_next  = crc_cnt_reg;
        crc_next      = crc_reg;
        good_next     = good_reg;
        bump_bad      = 1'b0;
        hdr_we        = 1'b0;
        route         = 1'b0;
        byte_v        = in_byte;
        crc_upd       = crc_byte(crc_reg, byte_v, cfg.crc_polynomial);

        res                = '0;
        res.kind           = KIND_NONE;
        res.error_cause    = CAUSE_NONE;

        case (mode_reg)
            MODE_WAIT:
            begin
                if (in_byte == cfg.start_byte)
                begin
                    position_next = '0;
                    length_next   = '0;
                    rx_crc_next   = '0;
                    crc_cnt_next  = '0;
                    crc_next      = cfg.crc_initial;
                    mode_next     = MODE_FRAME;
                end
            end
            MODE_FRAME:
            begin
                // Escape wins over start, start wins over end.
                if (in_byte == cfg.escape_byte)
                begin
                    mode_next = MODE_ESC;
                end
                else if (in_byte == cfg.start_byte)
                begin
                    position_next   = '0;
                    length_next     = '0;
                    rx_crc_next     = '0;
                    crc_cnt_next    = '0;
                    crc_next        = cfg.crc_initial;
                    bump_bad        = 1'b1;
                    res.kind        = KIND_ERROR;
                    res.error_cause = CAUSE_RESTART;
                end
                else if (in_byte == cfg.end_byte)
                begin
                    mode_next = MODE_WAIT;
                    if (position_reg >= body_end && crc_cnt_reg == CRC_DONE)
                    begin
                        if (crc_reg == rx_crc_reg)
                        begin
                            good_next          = good_reg + 1'b1;
                            res.kind           = KIND_GOOD;
                            res.msg_first      = hdr_reg[0];
                            res.msg_second     = hdr_reg[1];
                            res.length_field   = length_reg;
                            res.cmd_first      = hdr_reg[4];
                            res.cmd_second     = hdr_reg[5];
                        end
                        else
                        begin
                            bump_bad        = 1'b1;
                            res.kind        = KIND_ERROR;
                            res.error_cause = CAUSE_CRC;
                        end
                    end
                    else
                    begin
                        bump_bad        = 1'b1;
                        res.kind        = KIND_ERROR;
                        res.error_cause = CAUSE_SHORT;
                    end
                end
                else
                begin
                    route = 1'b1;
                end
            end
            default:
            begin
                // The byte after an escape is always data.
                byte_v    = in_byte ^ cfg.escape_byte;
                crc_upd   = crc_byte(crc_reg, byte_v, cfg.crc_polynomial);
                mode_next = MODE_FRAME;
                route     = 1'b1;
            end
        endcase

        if (route)
        begin
            if (position_reg < HDR_END)
            begin
                hdr_we   = 1'b1;
                crc_next = crc_upd;
                if (position_reg == LEN_LOW && len_new > cfg.max_payload)
                begin
                    // Oversize length: the frame is dropped here.
                    length_next     = len_new;
                    mode_next       = MODE_WAIT;
                    bump_bad        = 1'b1;
                    res.kind        = KIND_ERROR;
                    res.error_cause = CAUSE_LENGTH;
                end
                else
                begin
                    if (position_reg == LEN_LOW)
                        length_next = len_new;
                    res.kind       = KIND_HEADER;
                    res.data_byte  = byte_v;
                    res.byte_index = position_reg;
                    position_next  = position_reg + 1'b1;
                end
            end
            else if (position_reg < body_end)
            begin
                crc_next       = crc_upd;
                res.kind       = KIND_PAYLOAD;
                res.data_byte  = byte_v;
                res.byte_index = position_reg;
                position_next  = position_reg + 1'b1;
            end
            else if (crc_cnt_reg < CRC_DONE)
            begin
                rx_crc_next    = {rx_crc_reg[7:0], byte_v};
                crc_cnt_next   = crc_cnt_reg + 1'b1;
                res.kind       = KIND_CRC;
                res.data_byte  = byte_v;
                res.byte_index = position_reg;
                position_next  = position_reg + 1'b1;
            end
            else
            begin
                mode_next       = MODE_WAIT;
                bump_bad        = 1'b1;
                res.kind        = KIND_ERROR;
                res.error_cause = CAUSE_EXTRA;
            end
        end

        bad_next       = bump_bad ? bad_reg + 1'b1 : bad_reg;
        res.good_count = count_out(good_next);
        res.bad_count  = count_out(bad_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_WAIT;
            position_reg <= '0;
            length_reg   <= '0;
            rx_crc_reg   <= '0;
            crc_cnt_reg  <= '0;
            crc_reg      <= INIT_RST;
            good_reg     <= '0;
            bad_reg      <= '0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            position_reg <= position_next;
            length_reg   <= length_next;
            rx_crc_reg   <= rx_crc_next;
            crc_cnt_reg  <= crc_cnt_next;
            crc_reg      <= crc_next;
            good_reg     <= good_next;
            bad_reg      <= bad_next;
        end
    end

    // Header bytes hold no reset; each is written before it is read in a frame.
    always_ff @(posedge clk)
    begin
        if (step && hdr_we)
            hdr_reg[position_reg[2:0]] <= byte_v;
    end

endmodule

`default_nettype wire

[src/byte_stuffed_frame_receiver.sv]
// Top level of the byte-stuffed frame receiver with CRC-16 check.
//
//  Channel   Direction  Signals                          Contents
//  s_axis    in         s_tvalid s_tready s_tdata[7:0]   one raw line byte
//  m_axis    out        m_tvalid m_tready m_tuser m_tdata one result per byte
//  apb       in/out     psel penable pwrite paddr ...    six config registers
//
// Every accepted byte produces exactly one result request, kind none included.
// Throughput is one byte per cycle while the output is not stalled: the byte
// sits in an input register, the unstuffing, routing and byte-wide CRC-16
// update run in one pass of logic, and the result lands in an output register.
// A stalled output holds its result while the input register still accepts
// one more byte; the input stage frees up as soon as the result moves on.
// rst_n is asynchronous and clears all control state and the counters; the
// configuration registers return to their reset values.
`default_nettype none

module byte_stuffed_frame_receiver
    import bsfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Input stream.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] in_byte
    // Result stream.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [143:0]           m_tdata,   // [2:0] error_cause, [10:3] data_byte,
                                              // [27:11] byte_index, [35:28] msg_first,
                                              // [43:36] msg_second,
                                              // [59:44] length_field,
                                              // [67:60] cmd_first, [75:68] cmd_second,
                                              // [107:76] good_count,
                                              // [139:108] bad_count, [143:140] zero
    output logic [2:0]             m_tuser,   // [2:0] kind
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    cfg_t       cfg;
    res_t       res;
    res_t       out_res_reg;
    logic       out_valid_reg, out_valid_next;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       in_take;

    bsfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The byte in the input register is processed when the output register
    // is empty or its result is being taken in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    bsfr_deframer u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .in_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= s_tdata;
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {4'd0,
                       out_res_reg.bad_count,
                       out_res_reg.good_count,
                       out_res_reg.cmd_second,
                       out_res_reg.cmd_first,
                       out_res_reg.length_field,
                       out_res_reg.msg_second,
                       out_res_reg.msg_first,
                       out_res_reg.byte_index,
                       out_res_reg.data_byte,
                       out_res_reg.error_cause};

    // A processed byte always leaves a result in the output register.
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed byte left no result");

    // A byte that could not move on stays put and unchanged.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("waiting input byte was lost or changed");

    // Only error results carry a cause.
    a_cause_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.kind != KIND_ERROR
            |-> out_res_reg.error_cause == CAUSE_NONE)
        else $error("cause reported without error");

    a_error_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.kind == KIND_ERROR
            |-> out_res_reg.error_cause != CAUSE_NONE)
        else $error("error reported without cause");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the byte-stuffed frame receiver.
module tb_top
    import bsfr_pkg::*;
();

    // Register indexes on the configuration port; register i sits at byte address 4*i.
    localparam int REG_START = 0;
    localparam int REG_END   = 1;
    localparam int REG_ESC   = 2;
    localparam int REG_MAXP  = 3;
    localparam int REG_POLY  = 4;
    localparam int REG_INIT  = 5;

    // Receiver modes of the predictor.
    typedef enum logic [1:0] {RX_WAIT, RX_FRAME, RX_ESC} rx_mode_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    wire logic           s_tready;
    logic [7:0]          s_tdata = 8'h00;
    wire logic           m_tvalid;
    logic                m_tready = 1'b0;
    wire logic [143:0]   m_tdata;
    wire logic [2:0]     m_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = 32'd0;
    wire logic [31:0]    prdata;
    wire logic           pready;

    byte_stuffed_frame_receiver uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Line bytes waiting to be offered, and results the predictor has worked out
    // for every accepted request but the block has not delivered yet.
    logic [7:0] line_bytes[$];
    res_t       expected_results[$];
    logic [7:0] frame_body[$];

    // Predictor copy of the configuration and the receiver state.
    cfg_t        rx_cfg;
    rx_mode_t    rx_mode;
    logic [16:0] frame_pos;
    logic [15:0] ann_len;
    logic [15:0] got_crc;
    logic [1:0]  crc_seen;
    logic [15:0] run_crc;
    logic [7:0]  header_copy[0:5];
    // The counters are 32 bits wide in this build, so they wrap exactly as reported.
    logic [31:0] good_total;
    logic [31:0] bad_total;

    // Handshake pacing.
    logic byte_fired = 1'b0;
    bit   gaps_on = 1'b0;
    int   gap_odds = 7;
    int   send_gap = 0;
    int   take_gap = 0;

    // Bookkeeping.
    int sent_bytes = 0;
    int results_seen = 0;
    int mismatches = 0;
    int kind_seen[0:7];
    int cause_seen[0:7];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous fixed limit: the run stays well inside it even with every
    // request meeting the longest gap on both sides.
    initial
    begin
        #3_000_000;
        $display("byte_stuffed_frame_receiver verification failed");
        $finish;
    end

    // Byte-wide CRC-16, MSB first.
    function automatic logic [15:0] crc_feed_byte(input logic [15:0] crc, input logic [7:0] b,
                                                  input logic [15:0] poly);
        logic [15:0] c;
        int i;
        c = crc ^ {b, 8'h00};
        for (i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ poly) : (c << 1);
        return c;
    endfunction

    function automatic void clear_frame();
        frame_pos = '0;
        ann_len = '0;
        got_crc = '0;
        crc_seen = '0;
        run_crc = rx_cfg.crc_initial;
    endfunction

    // Works out the one result that a raw line byte causes, and advances the
    // predictor state. In a frame a byte is checked as escape first, then as
    // start, then as end; anything else (and any escaped byte) is frame data.
    function automatic res_t deframe_byte(input logic [7:0] raw);
        res_t        r;
        logic [7:0]  b;
        logic        steer;
        logic [16:0] body_end;
        r = '0;
        b = raw;
        steer = 1'b0;
        body_end = 17'(HDR_BYTES) + {1'b0, ann_len};
        case (rx_mode)
            RX_WAIT:
            begin
                if (b == rx_cfg.start_byte)
                begin
                    clear_frame();
                    rx_mode = RX_FRAME;
                end
            end
            RX_FRAME:
            begin
                if (b == rx_cfg.escape_byte)
                    rx_mode = RX_ESC;
                else if (b == rx_cfg.start_byte)
                begin
                    // A start inside a frame throws the frame away and opens a new one.
                    clear_frame();
                    bad_total++;
                    r.kind = KIND_ERROR;
                    r.error_cause = CAUSE_RESTART;
                end
                else if (b == rx_cfg.end_byte)
                begin
                    if (frame_pos >= body_end && crc_seen == CRC_LEN)
                    begin
                        if (run_crc == got_crc)
                        begin
                            good_total++;
                            r.kind = KIND_GOOD;
                            r.msg_first = header_copy[0];
                            r.msg_second = header_copy[1];
                            r.length_field = ann_len;
                            r.cmd_first = header_copy[4];
                            r.cmd_second = header_copy[5];
                        end
                        else
                        begin
                            bad_total++;
                            r.kind = KIND_ERROR;
                            r.error_cause = CAUSE_CRC;
                        end
                    end
                    else
                    begin
                        bad_total++;
                        r.kind = KIND_ERROR;
                        r.error_cause = CAUSE_SHORT;
                    end
                    rx_mode = RX_WAIT;
                end
                else
                    steer = 1'b1;
            end
            default:
            begin
                b = raw ^ rx_cfg.escape_byte;
                rx_mode = RX_FRAME;
                steer = 1'b1;
            end
        endcase

        if (steer)
        begin
            if (frame_pos < HDR_BYTES)
            begin
                header_copy[frame_pos[2:0]] = b;
                run_crc = crc_feed_byte(run_crc, b, rx_cfg.crc_polynomial);
                if (frame_pos == LEN_LOW_POS)
                begin
                    ann_len = {header_copy[LEN_HIGH_POS], b};
                    if (ann_len > rx_cfg.max_payload)
                    begin
                        rx_mode = RX_WAIT;
                        bad_total++;
                        r.kind = KIND_ERROR;
                        r.error_cause = CAUSE_LENGTH;
                        steer = 1'b0;
                    end
                end
                if (steer)
                begin
                    r.kind = KIND_HEADER;
                    r.data_byte = b;
                    r.byte_index = frame_pos;
                end
            end
            else if (frame_pos < body_end)
            begin
                run_crc = crc_feed_byte(run_crc, b, rx_cfg.crc_polynomial);
                r.kind = KIND_PAYLOAD;
                r.data_byte = b;
                r.byte_index = frame_pos;
            end
            else if (crc_seen < CRC_LEN)
            begin
                got_crc = {got_crc[7:0], b};
                crc_seen++;
                r.kind = KIND_CRC;
                r.data_byte = b;
                r.byte_index = frame_pos;
            end
            else
            begin
                // Data after both CRC bytes: the frame is dropped.
                rx_mode = RX_WAIT;
                bad_total++;
                r.kind = KIND_ERROR;
                r.error_cause = CAUSE_EXTRA;
                steer = 1'b0;
            end
            if (steer)
                frame_pos = frame_pos + 17'd1;
        end

        r.good_count = good_total;
        r.bad_count = bad_total;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            if (mismatches < 10)
                $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got);
            mismatches++;
        end
    endtask

    // Compares a delivered result with the oldest expectation, field by field.
    task automatic check_result();
        res_t want;
        if (expected_results.size() == 0)
        begin
            if (mismatches < 10)
                $display("MISMATCH result %0d arrived with nothing expected (kind %0d)",
                         results_seen, m_tuser);
            mismatches++;
        end
        else
        begin
            want = expected_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(m_tuser));
            check_field("error_cause", 32'(want.error_cause), 32'(m_tdata[2:0]));
            check_field("data_byte", 32'(want.data_byte), 32'(m_tdata[10:3]));
            check_field("byte_index", 32'(want.byte_index), 32'(m_tdata[27:11]));
            check_field("msg_first", 32'(want.msg_first), 32'(m_tdata[35:28]));
            check_field("msg_second", 32'(want.msg_second), 32'(m_tdata[43:36]));
            check_field("length_field", 32'(want.length_field), 32'(m_tdata[59:44]));
            check_field("cmd_first", 32'(want.cmd_first), 32'(m_tdata[67:60]));
            check_field("cmd_second", 32'(want.cmd_second), 32'(m_tdata[75:68]));
            check_field("good_count", want.good_count, m_tdata[107:76]);
            check_field("bad_count", want.bad_count, m_tdata[139:108]);
            check_field("padding", 32'd0, 32'(m_tdata[143:140]));
            kind_seen[want.kind]++;
            cause_seen[want.error_cause]++;
        end
        results_seen++;
    endtask

    // Sampling side: every accepted byte gets its expectation at the edge that
    // accepts it, and every accepted result is checked at its own edge. The
    // expectation goes in first so that the queue order holds for any latency.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            byte_fired <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(deframe_byte(s_tdata));
                void'(line_bytes.pop_front());
            end
            if (m_tvalid && m_tready)
                check_result();
        end
    end

    // Sender: a request that has not been taken is held; otherwise the next byte
    // goes out unless a random gap is running.
    always @(negedge clk)
    begin
        if (s_tvalid && !byte_fired)
        begin
            // Request still pending: hold valid and data.
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            s_tvalid <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, gap_odds) == 0)
        begin
            send_gap = $urandom_range(0, 8);
            s_tvalid <= 1'b0;
        end
        else if (line_bytes.size() != 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata <= line_bytes[0];
        end
        else
            s_tvalid <= 1'b0;
    end

    // Receiver: ready except during random stall bursts.
    always @(negedge clk)
    begin
        if (take_gap > 0)
        begin
            take_gap--;
            m_tready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, gap_odds) == 0)
        begin
            take_gap = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Waits until every queued byte is accepted and every expected result has
    // come back, then waits on falling clock edges before returning.
    task automatic settle();
        while (line_bytes.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready. The upper bits of
    // pwdata are random, since the register keeps only its own width.
    task automatic write_reg(input int idx, input logic [15:0] value);
        logic [31:0] word;
        word = $urandom;
        if (idx <= REG_ESC)
            word[7:0] = value[7:0];
        else
            word[15:0] = value;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_START: rx_cfg.start_byte = word[7:0];
            REG_END:   rx_cfg.end_byte = word[7:0];
            REG_ESC:   rx_cfg.escape_byte = word[7:0];
            REG_MAXP:  rx_cfg.max_payload = word[15:0];
            REG_POLY:  rx_cfg.crc_polynomial = word[15:0];
            REG_INIT:  rx_cfg.crc_initial = word[15:0];
            default:   ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] sb, input logic [7:0] eb, input logic [7:0] xb,
                              input logic [15:0] maxp, input logic [15:0] poly,
                              input logic [15:0] init);
        write_reg(REG_START, {8'h00, sb});
        write_reg(REG_END, {8'h00, eb});
        write_reg(REG_ESC, {8'h00, xb});
        write_reg(REG_MAXP, maxp);
        write_reg(REG_POLY, poly);
        write_reg(REG_INIT, init);
    endtask

    task automatic put_line(input logic [7:0] b);
        line_bytes.push_back(b);
        sent_bytes++;
    endtask

    // Byte stuffing: any data byte that looks like a control byte goes out as
    // escape followed by the byte XORed with the escape value.
    task automatic put_data(input logic [7:0] b);
        if (b == rx_cfg.start_byte || b == rx_cfg.end_byte || b == rx_cfg.escape_byte)
        begin
            put_line(rx_cfg.escape_byte);
            put_line(b ^ rx_cfg.escape_byte);
        end
        else
            put_line(b);
    endtask

    // Appends the big-endian CRC of the header and payload held in frame_body.
    task automatic close_body();
        logic [15:0] crc;
        crc = rx_cfg.crc_initial;
        foreach (frame_body[i])
            crc = crc_feed_byte(crc, frame_body[i], rx_cfg.crc_polynomial);
        frame_body.push_back(crc[15:8]);
        frame_body.push_back(crc[7:0]);
    endtask

    task automatic ship_body();
        put_line(rx_cfg.start_byte);
        foreach (frame_body[i])
            put_data(frame_body[i]);
        put_line(rx_cfg.end_byte);
    endtask

    // One random frame. Most are well formed; the rest carry a bad CRC, stop
    // early, run past the CRC, announce too long a payload, get cut off by a
    // fresh start, or are plain line noise between frames.
    task automatic send_frame();
        int pick;
        int cap;
        int len;
        int cut;
        bit oversize;
        logic [15:0] flen;
        pick = $urandom_range(0, 99);
        if (pick >= 94)
        begin
            // Noise is not counted toward the stimulus size.
            repeat ($urandom_range(1, 4))
                line_bytes.push_back(8'($urandom));
            return;
        end
        cap = (rx_cfg.max_payload < 12) ? int'(rx_cfg.max_payload) : 12;
        if ($urandom_range(0, 15) == 0)
            cap = (rx_cfg.max_payload < 48) ? int'(rx_cfg.max_payload) : 48;
        len = $urandom_range(0, cap);
        oversize = (pick >= 83 && pick < 88 && rx_cfg.max_payload != 16'hFFFF);
        if (oversize)
        begin
            len = int'(rx_cfg.max_payload) + $urandom_range(1, 300);
            if (len > 65535)
                len = 65535;
        end
        flen = len[15:0];

        frame_body.delete();
        frame_body.push_back(8'($urandom));
        frame_body.push_back(8'($urandom));
        frame_body.push_back(flen[15:8]);
        frame_body.push_back(flen[7:0]);
        frame_body.push_back(8'($urandom));
        frame_body.push_back(8'($urandom));
        repeat (oversize ? $urandom_range(0, 3) : len)
            frame_body.push_back(8'($urandom));
        close_body();

        if (pick >= 62 && pick < 70)
            frame_body[frame_body.size() - 1] ^= 8'(1 << $urandom_range(0, 7));
        else if (pick >= 70 && pick < 77)
        begin
            cut = $urandom_range(0, frame_body.size() - 1);
            while (frame_body.size() > cut)
                void'(frame_body.pop_back());
        end
        else if (pick >= 77 && pick < 83)
        begin
            repeat ($urandom_range(1, 3))
                frame_body.push_back(8'($urandom));
        end
        else if (pick >= 88)
        begin
            // A partial frame that the next start byte throws away.
            put_line(rx_cfg.start_byte);
            repeat ($urandom_range(0, 8))
                put_data(8'($urandom));
        end
        ship_body();
    endtask

    // Random frames until about `amount` line bytes are queued. With
    // pause_midway set the sender stops halfway until every result is back.
    task automatic run_random(input int amount, input bit pause_midway);
        int base;
        base = sent_bytes;
        while (sent_bytes - base < amount)
        begin
            send_frame();
            if (pause_midway && sent_bytes - base >= amount / 2)
            begin
                pause_midway = 1'b0;
                settle();
            end
        end
        settle();
    endtask

    initial
    begin
        logic [7:0] same;
        foreach (kind_seen[i])
        begin
            kind_seen[i] = 0;
            cause_seen[i] = 0;
        end
        rx_cfg.start_byte = START_RST;
        rx_cfg.end_byte = END_RST;
        rx_cfg.escape_byte = ESC_RST;
        rx_cfg.max_payload = MAXP_RST;
        rx_cfg.crc_polynomial = POLY_RST;
        rx_cfg.crc_initial = INIT_RST;
        rx_mode = RX_WAIT;
        clear_frame();
        foreach (header_copy[i])
            header_copy[i] = 8'h00;
        good_total = '0;
        bad_total = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed part, reset configuration and no gaps. Noise at both byte
        // extremes while waiting for a start.
        put_line(8'h00);
        put_line(8'hFF);
        // A good frame with an empty payload and extreme header bytes.
        frame_body.delete();
        frame_body = {8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'h7F};
        close_body();
        ship_body();
        // A start inside a frame restarts it; the end right after is a short frame.
        put_line(rx_cfg.start_byte);
        put_line(rx_cfg.start_byte);
        put_line(rx_cfg.end_byte);
        // An escaped end byte lands in the header as data, then a length of
        // 0xFFFF exceeds the payload limit.
        put_line(rx_cfg.start_byte);
        put_line(rx_cfg.escape_byte);
        put_line(rx_cfg.end_byte ^ rx_cfg.escape_byte);
        put_data(8'h00);
        put_data(8'hFF);
        put_data(8'hFF);
        settle();

        // Reset configuration with gaps, including one full drain halfway.
        gaps_on = 1'b1;
        gap_odds = 7;
        run_random(330, 1'b1);

        // Low extremes: empty payloads only, zero polynomial and initial value.
        set_config(8'h00, 8'hFF, 8'h80, 16'h0000, 16'h0000, 16'h0000);
        gap_odds = 3;
        run_random(280, 1'b0);

        // High extremes: any length is accepted, and escape shares the start value,
        // so inside a frame that value always escapes.
        set_config(8'hFF, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        gap_odds = 12;
        run_random(280, 1'b0);

        // Random control bytes and CRC, small payload limit.
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(0, 40)),
                   16'($urandom), 16'($urandom));
        gap_odds = 5;
        run_random(280, 1'b0);

        // Start, end and escape all equal: the escape test wins inside a frame.
        same = 8'($urandom);
        set_config(same, same, same, 16'd20, 16'h8005, 16'h0000);
        gap_odds = 9;
        run_random(180, 1'b0);

        // Start equal to end: an end byte inside a frame restarts it.
        set_config(8'h7E, 8'h7E, 8'h7D, 16'd64, 16'h1021, 16'h1D0F);
        gap_odds = 4;
        run_random(150, 1'b0);

        // Closing stretch at full rate, no gaps on either side.
        set_config(8'hC0, 8'hC1, 8'hDB, 16'd512, 16'h8BB7, 16'hFFFF);
        gaps_on = 1'b0;
        run_random(250, 1'b0);

        repeat (10) @(posedge clk);
        $display("Checked %0d results from %0d line bytes over seven register settings.",
                 results_seen, sent_bytes);
        $display("Packets good %0d; errors: restart %0d, short %0d, crc %0d, length %0d, extra %0d.",
                 kind_seen[KIND_GOOD], cause_seen[CAUSE_RESTART], cause_seen[CAUSE_SHORT],
                 cause_seen[CAUSE_CRC], cause_seen[CAUSE_LENGTH], cause_seen[CAUSE_EXTRA]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("byte_stuffed_frame_receiver verification clean");
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, expected_results.size());
            $display("byte_stuffed_frame_receiver verification failed");
        end
        $finish;
    end

endmodule
